@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion wrappers, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ rtl/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// csa_pkg
// Shared constants and types of the cosine similarity accumulator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int ELEM_WIDTH_DEF = 16;
    localparam int MAX_LEN_DEF    = 128;

    localparam int FRAC_BITS   = 15;
    localparam int SIM_W       = FRAC_BITS + 1;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int K_W         = $clog2(Q_W);
    localparam int SCALE_SHIFT = 2 * FRAC_BITS;

    localparam logic [SIM_W-1:0] SIM_MAX = {1'b0, {(SIM_W-1){1'b1}}};

    localparam int QUEUE_DEPTH = 2;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    typedef struct packed {
        logic [QCNT_W-1:0] count;
        logic              empty;
    } q_status_t;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MULP = 5'b00010,
        ST_MULR = 5'b00100,
        ST_ROOT = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

endpackage

@@ rtl/csa_front.sv @@
// ----------------------------------------------------------------------------
// csa_front
// Accepts element pairs, forms products, accumulates and queues finished
// vectors.
// ----------------------------------------------------------------------------
module csa_front #(
    parameter int ELEM_WIDTH = csa_pkg::ELEM_WIDTH_DEF,
    parameter int MAX_LEN    = csa_pkg::MAX_LEN_DEF,
    parameter int NORM_W     = 2 * ELEM_WIDTH - 1 + $clog2(MAX_LEN),
    parameter int JOB_W      = 3 * NORM_W + 2
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [ELEM_WIDTH-1:0] s_elem_a,
    input  logic signed [ELEM_WIDTH-1:0] s_elem_b,
    input  logic                         s_last_pair,
    input  csa_pkg::q_status_t           q_status,
    output logic                         push,
    output logic [JOB_W-1:0]             push_data
);

    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int DOT_W  = NORM_W + 1;
    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int OCC_W  = csa_pkg::QCNT_W + 1;

    logic                     accept;
    logic                     acc_en;
    logic                     job_ovf;
    logic [OCC_W-1:0]         occupancy;

    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ovf_reg, ovf_next;

    logic signed [PROD_W-1:0] mul_ab;
    logic signed [PROD_W-1:0] mul_aa;
    logic signed [PROD_W-1:0] mul_bb;

    logic                     pv_reg;
    logic                     plast_reg;
    logic                     povf_reg;
    logic signed [PROD_W-1:0] prod_ab_reg;
    logic signed [PROD_W-1:0] prod_aa_reg;
    logic signed [PROD_W-1:0] prod_bb_reg;

    logic signed [DOT_W-1:0]  dot_reg, dot_sum;
    logic [NORM_W-1:0]        na_reg, na_sum;
    logic [NORM_W-1:0]        nb_reg, nb_sum;

    // a last request still in the product stage holds a queue slot
    assign occupancy = OCC_W'(q_status.count) + OCC_W'(pv_reg & plast_reg);
    assign s_ready   = occupancy < OCC_W'(csa_pkg::QUEUE_DEPTH);
    assign accept    = s_valid & s_ready;
    assign acc_en    = count_reg < CNT_W'(MAX_LEN);
    assign job_ovf   = ovf_reg | ~acc_en;

    assign mul_ab = s_elem_a * s_elem_b;
    assign mul_aa = s_elem_a * s_elem_a;
    assign mul_bb = s_elem_b * s_elem_b;

    always_comb begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (accept) begin
            if (s_last_pair) begin
                count_next = '0;
                ovf_next   = 1'b0;
            end else begin
                if (acc_en) begin
                    count_next = count_reg + CNT_W'(1);
                end
                ovf_next = job_ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            pv_reg    <= 1'b0;
        end else begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            pv_reg    <= accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            plast_reg   <= s_last_pair;
            povf_reg    <= job_ovf;
            prod_ab_reg <= acc_en ? mul_ab : '0;
            prod_aa_reg <= acc_en ? mul_aa : '0;
            prod_bb_reg <= acc_en ? mul_bb : '0;
        end
    end

    assign dot_sum = dot_reg + DOT_W'(prod_ab_reg);
    assign na_sum  = na_reg + NORM_W'($unsigned(prod_aa_reg));
    assign nb_sum  = nb_reg + NORM_W'($unsigned(prod_bb_reg));

    assign push      = pv_reg & plast_reg;
    assign push_data = {povf_reg, dot_sum, na_sum, nb_sum};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            na_reg  <= '0;
            nb_reg  <= '0;
        end else if (pv_reg) begin
            if (plast_reg) begin
                dot_reg <= '0;
                na_reg  <= '0;
                nb_reg  <= '0;
            end else begin
                dot_reg <= dot_sum;
                na_reg  <= na_sum;
                nb_reg  <= nb_sum;
            end
        end
    end

endmodule

@@ rtl/csa_fifo.sv @@
// ----------------------------------------------------------------------------
// csa_fifo
// Short request queue between the accumulating front and the divider back.
// ----------------------------------------------------------------------------
module csa_fifo #(
    parameter int DATA_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [DATA_W-1:0]  push_data,
    input  logic               pop,
    output logic [DATA_W-1:0]  pop_data,
    output csa_pkg::q_status_t status
);

    localparam int PW = csa_pkg::QPTR_W;
    localparam int CW = csa_pkg::QCNT_W;

    logic [DATA_W-1:0] mem [csa_pkg::QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]     count_reg;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(csa_pkg::QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    assign pop_data     = mem[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = (count_reg == '0);

endmodule

@@ rtl/csa_back.sv @@
// ----------------------------------------------------------------------------
// csa_back
// Takes queued sums, forms normA*normB and dot^2 with a shift-add multiplier,
// builds the Q1.15 quotient bit by bit and holds the result for output.
// ----------------------------------------------------------------------------
module csa_back #(
    parameter int NORM_W = 38,
    parameter int JOB_W  = 3 * NORM_W + 2
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_empty,
    input  logic [JOB_W-1:0]                pop_data,
    output logic                            pop,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [csa_pkg::SIM_W-1:0] m_similarity,
    output logic                            m_zero_norm,
    output logic                            m_too_long
);

    localparam int DOT_W = NORM_W + 1;
    localparam int PW    = 2 * NORM_W;
    localparam int CW    = PW + csa_pkg::SCALE_SHIFT + 3;
    localparam int MC_W  = $clog2(NORM_W);
    localparam int SW    = csa_pkg::SIM_W;
    localparam int QW    = csa_pkg::Q_W;
    localparam int KW    = csa_pkg::K_W;

    csa_pkg::state_t state_reg, state_next;

    logic                    job_ovf;
    logic signed [DOT_W-1:0] job_dot;
    logic [NORM_W-1:0]       job_na, job_nb;
    logic [DOT_W-1:0]        job_abs;

    logic                    neg_reg, zero_reg, ovf_reg;
    logic [NORM_W-1:0]       mag_reg;

    logic [PW-1:0]           acc_reg, acc_step;
    logic [PW-1:0]           mcand_reg;
    logic [NORM_W-1:0]       mplier_reg;
    logic [MC_W-1:0]         mcnt_reg;
    logic                    mul_last;

    logic [CW-1:0]           r_reg, s_reg, tk_reg, pk_reg, cand;
    logic [QW-1:0]           q_reg;
    logic [KW-1:0]           k_reg;
    logic                    fits;

    logic                    load_out;
    logic [SW:0]             q_neg;
    logic [SW-1:0]           sim_val;
    logic                    m_valid_reg;
    logic [SW-1:0]           sim_reg;
    logic                    zero_out_reg, ovf_out_reg;

    assign {job_ovf, job_dot, job_na, job_nb} = pop_data;
    assign job_abs = job_dot[DOT_W-1] ? DOT_W'(-job_dot) : DOT_W'(job_dot);

    assign pop      = (state_reg == csa_pkg::ST_IDLE) & ~q_empty;
    assign acc_step = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign mul_last = (mcnt_reg == MC_W'(NORM_W - 1));
    assign cand     = s_reg + tk_reg + pk_reg;
    assign fits     = (cand <= r_reg);
    assign load_out = (state_reg == csa_pkg::ST_DONE) & (~m_valid_reg | m_ready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            csa_pkg::ST_IDLE: begin
                if (!q_empty) begin
                    if (job_na == '0 || job_nb == '0) begin
                        state_next = csa_pkg::ST_DONE;
                    end else begin
                        state_next = csa_pkg::ST_MULP;
                    end
                end
            end
            csa_pkg::ST_MULP: begin
                if (mul_last) begin
                    state_next = csa_pkg::ST_MULR;
                end
            end
            csa_pkg::ST_MULR: begin
                if (mul_last) begin
                    state_next = csa_pkg::ST_ROOT;
                end
            end
            csa_pkg::ST_ROOT: begin
                if (k_reg == '0) begin
                    state_next = csa_pkg::ST_DONE;
                end
            end
            csa_pkg::ST_DONE: begin
                if (load_out) begin
                    state_next = csa_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = csa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= csa_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            csa_pkg::ST_IDLE: begin
                neg_reg    <= job_dot[DOT_W-1];
                zero_reg   <= (job_na == '0) || (job_nb == '0);
                ovf_reg    <= job_ovf;
                mag_reg    <= NORM_W'(job_abs);
                acc_reg    <= '0;
                mcand_reg  <= PW'(job_na);
                mplier_reg <= job_nb;
                mcnt_reg   <= '0;
                q_reg      <= '0;
            end
            csa_pkg::ST_MULP, csa_pkg::ST_MULR: begin
                if (mul_last) begin
                    acc_reg    <= '0;
                    mcand_reg  <= PW'(mag_reg);
                    mplier_reg <= mag_reg;
                    mcnt_reg   <= '0;
                    if (state_reg == csa_pkg::ST_MULP) begin
                        pk_reg <= CW'(acc_step) << csa_pkg::SCALE_SHIFT;
                    end else begin
                        r_reg  <= CW'(acc_step) << csa_pkg::SCALE_SHIFT;
                        s_reg  <= '0;
                        tk_reg <= '0;
                        k_reg  <= KW'(QW - 1);
                    end
                end else begin
                    acc_reg    <= acc_step;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    mcnt_reg   <= mcnt_reg + MC_W'(1);
                end
            end
            csa_pkg::ST_ROOT: begin
                // S = q^2 P, Tk = q P << (k+1), Pk = P << 2k
                if (fits) begin
                    s_reg        <= cand;
                    tk_reg       <= (tk_reg + (pk_reg << 1)) >> 1;
                    q_reg[k_reg] <= 1'b1;
                end else begin
                    tk_reg <= tk_reg >> 1;
                end
                pk_reg <= pk_reg >> 2;
                k_reg  <= k_reg - KW'(1);
            end
            default: begin
            end
        endcase
    end

    assign q_neg = -{1'b0, q_reg};

    always_comb begin
        if (zero_reg) begin
            sim_val = '0;
        end else if (neg_reg) begin
            sim_val = q_neg[SW-1:0];
        end else if (q_reg > csa_pkg::SIM_MAX) begin
            sim_val = csa_pkg::SIM_MAX;
        end else begin
            sim_val = q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            sim_reg      <= sim_val;
            zero_out_reg <= zero_reg;
            ovf_out_reg  <= ovf_reg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_similarity = $signed(sim_reg);
    assign m_zero_norm  = zero_out_reg;
    assign m_too_long   = ovf_out_reg;

endmodule

@@ rtl/cosine_similarity_accumulator_top.sv @@
// Flow: the last pair passes the product registers, then is pushed into the queue;
//   the back multiplies and takes the root; a vector with a zero norm skips both.
// Throughput: one pair per cycle while s_ready is high; the back takes one vector
//   at a time, paced by the bit-serial shift-add multiplier and the bit-wise root.
// Reset: synchronous active-low aresetn clears sums, counters, queue and state.
// ----------------------------------------------------------------------------
// cosine_similarity_accumulator_top
// Streams element pairs and emits dot / sqrt(normA*normB) as Q1.15.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cosine_similarity_accumulator_top #(
    parameter int MAX_LEN    = csa_pkg::MAX_LEN_DEF,
    parameter int ELEM_WIDTH = csa_pkg::ELEM_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [ELEM_WIDTH-1:0]      s_elem_a,
    input  logic signed [ELEM_WIDTH-1:0]      s_elem_b,
    input  logic                              s_last_pair,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [csa_pkg::SIM_W-1:0]  m_similarity,
    output logic                              m_zero_norm,
    output logic                              m_too_long
);

    localparam int NORM_W = 2 * ELEM_WIDTH - 1 + $clog2(MAX_LEN);
    localparam int JOB_W  = 3 * NORM_W + 2;

    localparam logic [csa_pkg::QCNT_W-1:0] Q_FULL = csa_pkg::QCNT_W'(csa_pkg::QUEUE_DEPTH);

    csa_pkg::q_status_t q_status;
    logic               push, pop;
    logic [JOB_W-1:0]   push_data, pop_data;

    csa_front #(
        .ELEM_WIDTH (ELEM_WIDTH),
        .MAX_LEN    (MAX_LEN),
        .NORM_W     (NORM_W),
        .JOB_W      (JOB_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_elem_a    (s_elem_a),
        .s_elem_b    (s_elem_b),
        .s_last_pair (s_last_pair),
        .q_status    (q_status),
        .push        (push),
        .push_data   (push_data)
    );

    csa_fifo #(
        .DATA_W (JOB_W)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .status    (q_status)
    );

    csa_back #(
        .NORM_W (NORM_W),
        .JOB_W  (JOB_W)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_status.empty),
        .pop_data     (pop_data),
        .pop          (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_similarity (m_similarity),
        .m_zero_norm  (m_zero_norm),
        .m_too_long   (m_too_long)
    );

    `ASSERT_CLK(a_q_bound, q_status.count <= Q_FULL, "queue overfilled")
    `ASSERT_IMPL(a_push_room, push, q_status.count < Q_FULL, "push into full queue")
    `ASSERT_IMPL(a_pop_data, pop, !q_status.empty, "pop from empty queue")
    `ASSERT_IMPL(a_zero_sim, m_valid && m_zero_norm, m_similarity == '0, "zero norm, non-zero result")

endmodule
